/* rtl/assert_macros.svh */
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked in the same cycle, off during reset.
`define ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Implication checked in the next cycle, off during reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

/* rtl/ebrs_pkg.sv */
package ebrs_pkg;

  localparam int NUM_BUCKETS      = 512;
  localparam int TPB_LOG2         = 1;
  localparam int TICKS_PER_BUCKET = 1 << TPB_LOG2;
  localparam int BUCKET_AW        = $clog2(NUM_BUCKETS);
  localparam int COUNT_W          = $clog2(NUM_BUCKETS + 1);

  localparam int TICK_W   = 16;
  localparam int RANGE_W  = 8;
  localparam int LINE_W   = 8;
  localparam int DRIVE_W  = 8;
  localparam int PIDX_W   = 9;
  localparam int BUCKET_W = 16;
  localparam int SPEED_W  = 7;

  localparam int SHORTCUT_LIMIT   = 250;
  localparam int RIGHT_LINE_LIMIT = 205;
  localparam int LEFT_LINE_LIMIT6 = 1025;
  localparam int LEFT_LINE_GAIN   = 6;
  localparam int SPEED_GAIN       = 10;
  localparam int SPEED_MAX        = 100;
  localparam int SPEED_KNEE       = SPEED_MAX / SPEED_GAIN;

  typedef enum logic [1:0] {
    CMD_START = 2'd0,
    CMD_POLL  = 2'd1,
    CMD_PEAK  = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    REG_TARGET   = 2'd0,
    REG_TURN     = 2'd1,
    REG_REVERSE  = 2'd2,
    REG_SHORTCUT = 2'd3
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_POLL,
    ST_SCAN,
    ST_PEAK
  } state_t;

  typedef struct packed {
    logic [1:0]         command;
    logic [TICK_W-1:0]  encoder_count;
    logic [RANGE_W-1:0] range_sample;
    logic [LINE_W-1:0]  right_line;
    logic [LINE_W-1:0]  left_line;
  } req_t;

  typedef struct packed {
    logic signed [DRIVE_W-1:0] left_drive;
    logic signed [DRIVE_W-1:0] right_drive;
    logic                      move_done;
    logic                      shortcut_hit;
    logic [PIDX_W-1:0]         peak_index;
    logic [BUCKET_W-1:0]       peak_value;
    logic [TICK_W-1:0]         ticks_to_move;
    logic [TICK_W-1:0]         ticks_travelled;
  } rsp_t;

endpackage

/* rtl/ebrs_ram.sv */
module ebrs_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/encoder_binned_range_scan_drive_top.sv */
// channel   | handshake               | payload
// ----------+-------------------------+----------------------------------
// request   | req_valid / req_ready   | req (ebrs_pkg::req_t)
// response  | rsp_valid / rsp_ready   | rsp (ebrs_pkg::rsp_t), one per request
// config    | cfg_we                  | cfg_index, cfg_data (write only)
//
// Poll: bucket read, then add/write-back through the one RAM port pair.
// Start: response at once, then a clear of all NUM_BUCKETS buckets with req_ready low.
// Peak: a walk over the bucket_count live buckets, one bucket read per cycle.
// Other requests (stopped poll, unused code): answered directly from idle.
// After rst the same clear of all buckets runs before the first request is taken.
// A response held by rsp_ready low blocks the next request until it is taken.
module encoder_binned_range_scan_drive_top (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  req_valid,
  output logic                  req_ready,
  input  ebrs_pkg::req_t        req,
  output logic                  rsp_valid,
  input  logic                  rsp_ready,
  output ebrs_pkg::rsp_t        rsp,
  input  logic                  cfg_we,
  input  logic [1:0]            cfg_index,
  input  logic [15:0]           cfg_data
);

  localparam int BKT_W = ebrs_pkg::TICK_W - ebrs_pkg::TPB_LOG2;

  // configuration
  logic [ebrs_pkg::TICK_W-1:0] target_ticks;
  logic                        turn_mode;
  logic                        reverse_mode;
  logic                        allow_shortcut;

  // architectural state
  logic [ebrs_pkg::COUNT_W-1:0] bucket_count, bucket_count_next;
  logic [ebrs_pkg::TICK_W-1:0]  previous_tick, previous_tick_next;
  logic [ebrs_pkg::TICK_W-1:0]  recorded_ticks, recorded_ticks_next;
  logic                         shortcut_flag, shortcut_flag_next;
  logic                         stopped_flag, stopped_flag_next;

  // sequencer
  ebrs_pkg::state_t               state, state_next;
  logic [ebrs_pkg::BUCKET_AW-1:0] clr_idx, clr_idx_next;
  logic [ebrs_pkg::COUNT_W-1:0]   scan_idx, scan_idx_next;
  logic                           scan_vld, scan_vld_next;
  logic [ebrs_pkg::BUCKET_AW-1:0] scan_ridx, scan_ridx_next;
  logic [ebrs_pkg::BUCKET_AW-1:0] best_idx, best_idx_next;
  logic [ebrs_pkg::BUCKET_W-1:0]  best_val, best_val_next;
  ebrs_pkg::req_t                 req_q;
  logic                           stop_q;
  logic                           bkt_ok_q;

  // RAM port
  logic                           ram_we;
  logic [ebrs_pkg::BUCKET_AW-1:0] ram_waddr, ram_raddr;
  logic [ebrs_pkg::BUCKET_W-1:0]  ram_wdata, ram_rdata;

  // datapath
  logic                           req_fire;
  logic [BKT_W-1:0]               in_bkt, q_bkt;
  logic                           in_bkt_ok;
  logic                           at_target, on_line, stop_now;
  logic [10:0]                    left_scaled;
  logic [ebrs_pkg::TICK_W:0]      cnt_sum;
  logic [BKT_W:0]                 cnt_full;
  logic                           upd;
  logic [ebrs_pkg::BUCKET_W-1:0]  sum;
  logic                           cut;
  logic [ebrs_pkg::TICK_W-1:0]    tgt_diff;
  logic [ebrs_pkg::SPEED_W-1:0]   spd;
  logic signed [ebrs_pkg::DRIVE_W-1:0] spd_s;
  logic [ebrs_pkg::TICK_W-1:0]    from_tick;
  logic [ebrs_pkg::TICK_W:0]      peak_gap;
  logic                           fin;
  ebrs_pkg::rsp_t                 res;

  assign req_ready = (state == ebrs_pkg::ST_IDLE) && (!rsp_valid || rsp_ready);
  assign req_fire  = req_valid && req_ready;

  assign in_bkt    = req.encoder_count[ebrs_pkg::TICK_W-1:ebrs_pkg::TPB_LOG2];
  assign q_bkt     = req_q.encoder_count[ebrs_pkg::TICK_W-1:ebrs_pkg::TPB_LOG2];
  assign in_bkt_ok = 32'(in_bkt) < ebrs_pkg::NUM_BUCKETS;

  assign at_target   = (target_ticks != '0) && (req.encoder_count >= target_ticks);
  assign left_scaled = 11'(req.left_line) * 11'(ebrs_pkg::LEFT_LINE_GAIN);
  assign on_line     = !reverse_mode &&
                       ((req.right_line >= 8'(ebrs_pkg::RIGHT_LINE_LIMIT)) ||
                        (left_scaled >= 11'(ebrs_pkg::LEFT_LINE_LIMIT6)));
  assign stop_now    = at_target || on_line;

  // bucket_count = min(ceil(target / ticks per bucket), NUM_BUCKETS)
  assign cnt_sum  = 17'(target_ticks) + 17'(ebrs_pkg::TICKS_PER_BUCKET - 1);
  assign cnt_full = cnt_sum[ebrs_pkg::TICK_W:ebrs_pkg::TPB_LOG2];

  // poll update, valid in ST_POLL with rdata from the bucket of req_q
  assign upd = (req_q.encoder_count != previous_tick) && bkt_ok_q;
  assign sum = ram_rdata + 16'(req_q.range_sample);
  assign cut = upd && !reverse_mode && allow_shortcut &&
               (sum > 16'(ebrs_pkg::SHORTCUT_LIMIT));

  // not stopped, so encoder < target whenever target is nonzero
  assign tgt_diff = target_ticks - req_q.encoder_count;
  always_comb begin
    if (target_ticks == '0 || tgt_diff >= 16'(ebrs_pkg::SPEED_KNEE)) begin
      spd = 7'(ebrs_pkg::SPEED_MAX);
    end else begin
      spd = 7'(tgt_diff[3:0]) * 7'(ebrs_pkg::SPEED_GAIN);
    end
  end
  assign spd_s = $signed({1'b0, spd});

  // center of the bucket before the peak
  assign from_tick = (16'(best_idx) << ebrs_pkg::TPB_LOG2) -
                     16'(ebrs_pkg::TICKS_PER_BUCKET - ebrs_pkg::TICKS_PER_BUCKET / 2);
  assign peak_gap  = {1'b0, recorded_ticks} - {1'b0, from_tick};

  always_comb begin
    state_next          = state;
    bucket_count_next   = bucket_count;
    previous_tick_next  = previous_tick;
    recorded_ticks_next = recorded_ticks;
    shortcut_flag_next  = shortcut_flag;
    stopped_flag_next   = stopped_flag;
    clr_idx_next        = clr_idx;
    scan_idx_next       = scan_idx;
    scan_vld_next       = scan_vld;
    scan_ridx_next      = scan_ridx;
    best_idx_next       = best_idx;
    best_val_next       = best_val;
    ram_we              = 1'b0;
    ram_waddr           = q_bkt[ebrs_pkg::BUCKET_AW-1:0];
    ram_wdata           = sum;
    ram_raddr           = in_bkt[ebrs_pkg::BUCKET_AW-1:0];
    fin                 = 1'b0;
    res                 = '0;

    unique case (state)
      ebrs_pkg::ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_idx;
        ram_wdata = '0;
        clr_idx_next = clr_idx + 1'b1;
        if (clr_idx == ebrs_pkg::BUCKET_AW'(ebrs_pkg::NUM_BUCKETS - 1)) begin
          state_next = ebrs_pkg::ST_IDLE;
        end
      end

      ebrs_pkg::ST_IDLE: begin
        if (req_fire) begin
          unique case (req.command)
            ebrs_pkg::CMD_START: begin
              if (32'(cnt_full) > ebrs_pkg::NUM_BUCKETS) begin
                bucket_count_next = ebrs_pkg::COUNT_W'(ebrs_pkg::NUM_BUCKETS);
              end else begin
                bucket_count_next = ebrs_pkg::COUNT_W'(cnt_full);
              end
              previous_tick_next = '0;
              shortcut_flag_next = 1'b0;
              stopped_flag_next  = 1'b0;
              clr_idx_next       = '0;
              state_next         = ebrs_pkg::ST_CLEAR;
              fin                = 1'b1;
            end
            ebrs_pkg::CMD_POLL: begin
              if (stopped_flag) begin
                fin = 1'b1;
              end else begin
                state_next = ebrs_pkg::ST_POLL;
              end
            end
            ebrs_pkg::CMD_PEAK: begin
              best_idx_next = '0;
              best_val_next = '0;
              scan_idx_next = '0;
              scan_vld_next = 1'b0;
              state_next    = ebrs_pkg::ST_SCAN;
            end
            default: begin
              fin = 1'b1;
            end
          endcase
        end
      end

      ebrs_pkg::ST_POLL: begin
        fin        = 1'b1;
        state_next = ebrs_pkg::ST_IDLE;
        if (stop_q) begin
          stopped_flag_next   = 1'b1;
          recorded_ticks_next = req_q.encoder_count;
        end else begin
          ram_we = upd;
          if (cut) begin
            shortcut_flag_next = 1'b1;
            stopped_flag_next  = 1'b1;
          end else begin
            previous_tick_next = req_q.encoder_count;
            // left motor is mirrored
            res.left_drive  = (turn_mode ^ reverse_mode) ? spd_s : -spd_s;
            res.right_drive = reverse_mode ? -spd_s : spd_s;
          end
        end
      end

      ebrs_pkg::ST_SCAN: begin
        ram_raddr = scan_idx[ebrs_pkg::BUCKET_AW-1:0];
        if (scan_vld && ram_rdata > best_val) begin
          best_val_next = ram_rdata;
          best_idx_next = scan_ridx;
        end
        if (scan_idx < bucket_count) begin
          scan_idx_next  = scan_idx + 1'b1;
          scan_vld_next  = 1'b1;
          scan_ridx_next = scan_idx[ebrs_pkg::BUCKET_AW-1:0];
        end else begin
          scan_vld_next = 1'b0;
          if (!scan_vld) begin
            state_next = ebrs_pkg::ST_PEAK;
          end
        end
      end

      ebrs_pkg::ST_PEAK: begin
        fin               = 1'b1;
        state_next        = ebrs_pkg::ST_IDLE;
        res.peak_index    = ebrs_pkg::PIDX_W'(best_idx);
        res.peak_value    = best_val;
        res.ticks_to_move = peak_gap[ebrs_pkg::TICK_W] ? 16'(-peak_gap)
                                                        : peak_gap[ebrs_pkg::TICK_W-1:0];
      end

      default: begin
        state_next = ebrs_pkg::ST_IDLE;
      end
    endcase

    res.move_done       = stopped_flag_next;
    res.shortcut_hit    = shortcut_flag_next;
    res.ticks_travelled = recorded_ticks_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ebrs_pkg::ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bucket_count   <= '0;
      previous_tick  <= '0;
      recorded_ticks <= '0;
      shortcut_flag  <= 1'b0;
      stopped_flag   <= 1'b1;
      clr_idx        <= '0;
      scan_vld       <= 1'b0;
      rsp_valid      <= 1'b0;
    end else begin
      bucket_count   <= bucket_count_next;
      previous_tick  <= previous_tick_next;
      recorded_ticks <= recorded_ticks_next;
      shortcut_flag  <= shortcut_flag_next;
      stopped_flag   <= stopped_flag_next;
      clr_idx        <= clr_idx_next;
      scan_vld       <= scan_vld_next;
      if (fin) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    scan_idx  <= scan_idx_next;
    scan_ridx <= scan_ridx_next;
    best_idx  <= best_idx_next;
    best_val  <= best_val_next;
    if (req_fire) begin
      req_q    <= req;
      stop_q   <= stop_now;
      bkt_ok_q <= in_bkt_ok;
    end
    if (fin) begin
      rsp <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      target_ticks   <= '0;
      turn_mode      <= 1'b0;
      reverse_mode   <= 1'b0;
      allow_shortcut <= 1'b0;
    end else if (cfg_we) begin
      unique case (ebrs_pkg::reg_idx_t'(cfg_index))
        ebrs_pkg::REG_TARGET:   target_ticks   <= cfg_data;
        ebrs_pkg::REG_TURN:     turn_mode      <= cfg_data[0];
        ebrs_pkg::REG_REVERSE:  reverse_mode   <= cfg_data[0];
        ebrs_pkg::REG_SHORTCUT: allow_shortcut <= cfg_data[0];
      endcase
    end
  end

  ebrs_ram #(
    .WIDTH (ebrs_pkg::BUCKET_W),
    .DEPTH (ebrs_pkg::NUM_BUCKETS)
  ) u_bucket_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

endmodule

/* rtl/ebrs_checker.sv */
`include "assert_macros.svh"

module ebrs_checker (
  input logic           clk,
  input logic           rst,
  input logic           rsp_valid,
  input logic           rsp_ready,
  input ebrs_pkg::rsp_t rsp
);

  logic driving;

  assign driving = (rsp.left_drive != 8'sd0) || (rsp.right_drive != 8'sd0);

  // wheels only turn while the move is still running
  `ASSERT_SAME(a_drive_running, clk, rst, rsp_valid && driving, !rsp.move_done && !rsp.shortcut_hit)

  // a shortcut always ends the move
  `ASSERT_SAME(a_shortcut_stops, clk, rst, rsp_valid && rsp.shortcut_hit, rsp.move_done)

  // an empty peak points at bucket zero
  `ASSERT_SAME(a_empty_peak, clk, rst, rsp_valid && (rsp.peak_value == 16'd0), rsp.peak_index == 9'd0)

  // stalled response holds
  `ASSERT_NEXT(a_rsp_hold, clk, rst, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp))

endmodule

bind encoder_binned_range_scan_drive_top ebrs_checker u_ebrs_checker (.*);

/* bench/testbench.sv */
`timescale 1ns / 100ps

module testbench;

  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int SETTLE_CYCLES = 600;   // covers the bucket clear and a full peak walk
  localparam int DRAIN_LIMIT   = 20000;
  localparam int RUN_LIMIT_NS  = 40_000_000;
  localparam int ITEM_GOAL     = 1275;

  typedef enum logic {ROW_SET, ROW_REQ} row_kind_t;

  typedef struct {
    row_kind_t      kind;
    ebrs_pkg::req_t item;
    logic [15:0]    target;
    logic           spin;
    logic           back;
    logic           early;
    bit             golden;
    ebrs_pkg::rsp_t want;
  } plan_row_t;

  logic           clk = 1'b0;
  logic           rst = 1'b1;
  logic           req_valid = 1'b0;
  logic           req_ready;
  ebrs_pkg::req_t req = '0;
  logic           rsp_valid;
  logic           rsp_ready = 1'b0;
  ebrs_pkg::rsp_t rsp;
  logic           cfg_we = 1'b0;
  logic [1:0]     cfg_index = '0;
  logic [15:0]    cfg_data = '0;

  // typed-in expectation that rides along with the request payload
  bit             req_golden_en = 1'b0;
  ebrs_pkg::rsp_t req_golden = '0;

  // vehicle model state
  logic [15:0] cfg_target = '0;
  logic        cfg_spin = 1'b0;
  logic        cfg_back = 1'b0;
  logic        cfg_early = 1'b0;
  logic [15:0] slot_sum [ebrs_pkg::NUM_BUCKETS];
  int          slots_live = 0;
  logic [15:0] last_tick = '0;
  logic [15:0] stop_ticks = '0;
  logic        cut_seen = 1'b0;
  logic        halted = 1'b1;

  ebrs_pkg::rsp_t pending_status [$];
  ebrs_pkg::rsp_t want_status;
  plan_row_t      plan [$];
  bit          calm = 1'b0;
  int          errors = 0;
  int          sent = 0;
  int          checked = 0;
  int          moves_seen = 0;
  int          peaks_seen = 0;
  int          target_stops = 0;
  int          line_stops = 0;
  int          shortcut_stops = 0;

  encoder_binned_range_scan_drive_top u_dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic ebrs_pkg::rsp_t pack_status(input logic [7:0] lft, input logic [7:0] rgt,
                                       input logic done, input logic cut,
                                       input logic [8:0] pk_i, input logic [15:0] pk_v,
                                       input logic [15:0] pk_m, input logic [15:0] trav);
    ebrs_pkg::rsp_t o;
    o.left_drive      = lft;
    o.right_drive     = rgt;
    o.move_done       = done;
    o.shortcut_hit    = cut;
    o.peak_index      = pk_i;
    o.peak_value      = pk_v;
    o.ticks_to_move   = pk_m;
    o.ticks_travelled = trav;
    return o;
  endfunction

  function automatic ebrs_pkg::req_t mk_req(input logic [1:0] c, input logic [15:0] e,
                                  input logic [7:0] rg, input logic [7:0] rl,
                                  input logic [7:0] ll);
    ebrs_pkg::req_t r;
    r.command       = c;
    r.encoder_count = e;
    r.range_sample  = rg;
    r.right_line    = rl;
    r.left_line     = ll;
    return r;
  endfunction

  function automatic plan_row_t req_row(input logic [1:0] c, input logic [15:0] e,
                                        input logic [7:0] rg, input logic [7:0] rl,
                                        input logic [7:0] ll);
    plan_row_t p;
    p        = '{kind: ROW_REQ, target: '0, spin: 1'b0, back: 1'b0, early: 1'b0,
                 golden: 1'b0, item: '0, want: '0};
    p.item   = mk_req(c, e, rg, rl, ll);
    return p;
  endfunction

  function automatic plan_row_t chk_row(input logic [1:0] c, input logic [15:0] e,
                                        input logic [7:0] rg, input logic [7:0] rl,
                                        input logic [7:0] ll, input ebrs_pkg::rsp_t w);
    plan_row_t p;
    p        = req_row(c, e, rg, rl, ll);
    p.golden = 1'b1;
    p.want   = w;
    return p;
  endfunction

  function automatic plan_row_t set_row(input logic [15:0] tgt, input logic spin,
                                        input logic back, input logic early);
    plan_row_t p;
    p        = req_row(ebrs_pkg::CMD_START, '0, '0, '0, '0);
    p.kind   = ROW_SET;
    p.target = tgt;
    p.spin   = spin;
    p.back   = back;
    p.early  = early;
    return p;
  endfunction

  // Advances the vehicle model by one request and returns the status it reports.
  function automatic ebrs_pkg::rsp_t next_drive_status(input ebrs_pkg::req_t r);
    int          spd;
    int          ls;
    int          rs;
    int          lft;
    int          rgt;
    int          slot;
    int          face_tick;
    int          gap_ticks;
    bit          stop_now;
    bit          on_line;
    bit          cut;
    logic [8:0]  pk_i;
    logic [15:0] pk_v;
    logic [15:0] pk_m;
    lft  = 0;
    rgt  = 0;
    pk_i = '0;
    pk_v = '0;
    pk_m = '0;
    case (r.command)
      ebrs_pkg::CMD_START: begin
        foreach (slot_sum[k]) slot_sum[k] = '0;
        slots_live = (int'(cfg_target) + ebrs_pkg::TICKS_PER_BUCKET - 1) /
                     ebrs_pkg::TICKS_PER_BUCKET;
        if (slots_live > ebrs_pkg::NUM_BUCKETS) slots_live = ebrs_pkg::NUM_BUCKETS;
        last_tick  = '0;
        cut_seen   = 1'b0;
        halted     = 1'b0;
        moves_seen++;
      end
      ebrs_pkg::CMD_POLL: if (!halted) begin
        on_line  = !cfg_back &&
                   (int'(r.right_line) >= ebrs_pkg::RIGHT_LINE_LIMIT ||
                    int'(r.left_line) * ebrs_pkg::LEFT_LINE_GAIN >= ebrs_pkg::LEFT_LINE_LIMIT6);
        stop_now = (cfg_target != 0 && r.encoder_count >= cfg_target) || on_line;
        if (stop_now) begin
          halted     = 1'b1;
          stop_ticks = r.encoder_count;
          if (on_line) line_stops++;
          else target_stops++;
        end else begin
          cut  = 1'b0;
          slot = int'(r.encoder_count) / ebrs_pkg::TICKS_PER_BUCKET;
          if (r.encoder_count != last_tick && slot < ebrs_pkg::NUM_BUCKETS) begin
            slot_sum[slot] = slot_sum[slot] + 16'(r.range_sample);
            cut = !cfg_back && cfg_early && int'(slot_sum[slot]) > ebrs_pkg::SHORTCUT_LIMIT;
          end
          if (cut) begin
            cut_seen = 1'b1;
            halted   = 1'b1;
            shortcut_stops++;
          end else begin
            last_tick = r.encoder_count;
            spd = ebrs_pkg::SPEED_MAX;
            if (cfg_target != 0) begin
              spd = ebrs_pkg::SPEED_GAIN * (int'(cfg_target) - int'(r.encoder_count));
              if (spd > ebrs_pkg::SPEED_MAX) spd = ebrs_pkg::SPEED_MAX;
            end
            ls = spd;
            rs = spd;
            if (cfg_spin) begin
              if (!cfg_back) ls = -ls;
              else rs = -rs;
            end else if (cfg_back) begin
              ls = -ls;
              rs = -rs;
            end
            // left motor is mounted mirrored
            lft = -ls;
            rgt = rs;
          end
        end
      end
      ebrs_pkg::CMD_PEAK: begin
        for (int k = 0; k < slots_live; k++) begin
          if (slot_sum[k] > pk_v) begin
            pk_v = slot_sum[k];
            pk_i = 9'(k);
          end
        end
        // center tick of the bucket before the peak, wrapped to 16 bits
        face_tick = (int'(pk_i) * ebrs_pkg::TICKS_PER_BUCKET - ebrs_pkg::TICKS_PER_BUCKET +
                     ebrs_pkg::TICKS_PER_BUCKET / 2) & 32'hFFFF;
        gap_ticks = int'(stop_ticks) - face_tick;
        if (gap_ticks < 0) gap_ticks = -gap_ticks;
        pk_m = gap_ticks[15:0];
        peaks_seen++;
      end
      default: ;
    endcase
    return pack_status(lft[7:0], rgt[7:0], halted, cut_seen, pk_i, pk_v, pk_m, stop_ticks);
  endfunction

  task automatic report_mismatch(input string what);
    $display("[%0t] MISMATCH: %s", $time, what);
    errors++;
  endtask

  task automatic check_field(input string name, input logic [15:0] got,
                             input logic [15:0] exp_val);
    if (got !== exp_val)
      report_mismatch($sformatf("%s got 0x%0h, expected 0x%0h", name, got, exp_val));
  endtask

  // request acceptance feeds the model first, then any response is checked
  always @(posedge clk) begin
    if (!rst) begin
      if (req_valid && req_ready) begin
        want_status = next_drive_status(req);
        if (req_golden_en) want_status = req_golden;
        pending_status.push_back(want_status);
      end
      if (rsp_valid && rsp_ready) begin
        if (pending_status.size() == 0) begin
          report_mismatch("response with no request outstanding");
        end else begin
          want_status = pending_status.pop_front();
          check_field("left_drive", 16'(rsp.left_drive), 16'(want_status.left_drive));
          check_field("right_drive", 16'(rsp.right_drive), 16'(want_status.right_drive));
          check_field("move_done", 16'(rsp.move_done), 16'(want_status.move_done));
          check_field("shortcut_hit", 16'(rsp.shortcut_hit), 16'(want_status.shortcut_hit));
          check_field("peak_index", 16'(rsp.peak_index), 16'(want_status.peak_index));
          check_field("peak_value", rsp.peak_value, want_status.peak_value);
          check_field("ticks_to_move", rsp.ticks_to_move, want_status.ticks_to_move);
          check_field("ticks_travelled", rsp.ticks_travelled, want_status.ticks_travelled);
          checked++;
        end
      end
    end
  end

  always @(posedge clk) begin
    rsp_ready <= calm || ($urandom_range(0, 99) >= 15);
  end

  task automatic issue(input ebrs_pkg::req_t r, input bit golden, input ebrs_pkg::rsp_t w);
    int unsigned gap;
    gap = 0;
    while (!calm && $urandom_range(0, 99) < 15) gap++;
    if (gap != 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req           <= r;
    req_golden_en <= golden;
    req_golden    <= w;
    req_valid     <= 1'b1;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
    sent++;
  endtask

  task automatic wait_drained();
    int unsigned spin_cnt;
    spin_cnt = 0;
    req_valid <= 1'b0;
    @(posedge clk);
    while (pending_status.size() != 0 && spin_cnt < DRAIN_LIMIT) begin
      @(posedge clk);
      spin_cnt++;
    end
    if (pending_status.size() != 0) begin
      report_mismatch($sformatf("%0d responses never arrived", pending_status.size()));
      pending_status.delete();
    end
  endtask

  // Only while idle: drain, let any clear or peak walk finish, then write all registers.
  task automatic reconfigure(input logic [15:0] tgt, input logic spin, input logic back,
                             input logic early);
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= ebrs_pkg::REG_TARGET;
    cfg_data  <= tgt;
    @(posedge clk);
    cfg_index <= ebrs_pkg::REG_TURN;
    cfg_data  <= {15'd0, spin};
    @(posedge clk);
    cfg_index <= ebrs_pkg::REG_REVERSE;
    cfg_data  <= {15'd0, back};
    @(posedge clk);
    cfg_index <= ebrs_pkg::REG_SHORTCUT;
    cfg_data  <= {15'd0, early};
    @(posedge clk);
    cfg_we     <= 1'b0;
    cfg_target = tgt;
    cfg_spin   = spin;
    cfg_back   = back;
    cfg_early  = early;
  endtask

  initial begin
    #(RUN_LIMIT_NS);
    $display("Run exceeded its time limit");
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    int          move;
    int          n_polls;
    bit          heavy;
    bit          dense;
    logic [15:0] tgt;
    logic        spin;
    logic        back;
    logic        early;
    logic [15:0] base;
    logic [15:0] enc;
    logic [7:0]  rg;
    logic [7:0]  rl;
    logic [7:0]  ll;

    foreach (slot_sum[k]) slot_sum[k] = '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // straight out of reset: stopped, no buckets, peak faces tick 0xFFFF
    plan.push_back(chk_row(ebrs_pkg::CMD_POLL, 16'd0, 8'd0, 8'd0, 8'd0,
                           pack_status(8'd0, 8'd0, 1'b1, 1'b0, 9'd0, 16'd0, 16'd0, 16'd0)));
    plan.push_back(chk_row(ebrs_pkg::CMD_PEAK, 16'd0, 8'd0, 8'd0, 8'd0,
                           pack_status(8'd0, 8'd0, 1'b1, 1'b0, 9'd0, 16'd0, 16'hFFFF, 16'd0)));
    plan.push_back(chk_row(CMD_UNUSED, 16'd0, 8'd0, 8'd0, 8'd0,
                           pack_status(8'd0, 8'd0, 1'b1, 1'b0, 9'd0, 16'd0, 16'd0, 16'd0)));
    // run to line edge, shortcut armed: one full-scale sample trips it
    plan.push_back(set_row(16'd0, 1'b0, 1'b0, 1'b1));
    plan.push_back(chk_row(ebrs_pkg::CMD_START, 16'd0, 8'd0, 8'd0, 8'd0,
                           pack_status(8'd0, 8'd0, 1'b0, 1'b0, 9'd0, 16'd0, 16'd0, 16'd0)));
    plan.push_back(chk_row(ebrs_pkg::CMD_POLL, 16'd1, 8'd100, 8'd0, 8'd0,
                           pack_status(-8'sd100, 8'd100, 1'b0, 1'b0, 9'd0, 16'd0, 16'd0,
                                       16'd0)));
    plan.push_back(chk_row(ebrs_pkg::CMD_POLL, 16'd2, 8'd255, 8'd0, 8'd0,
                           pack_status(8'd0, 8'd0, 1'b1, 1'b1, 9'd0, 16'd0, 16'd0, 16'd0)));
    plan.push_back(req_row(ebrs_pkg::CMD_POLL, 16'd3, 8'd9, 8'd0, 8'd0));
    plan.push_back(req_row(ebrs_pkg::CMD_PEAK, 16'd0, 8'd0, 8'd0, 8'd0));
    // max target, spin: sensors just under threshold, last bucket, past last bucket, left-line stop
    plan.push_back(set_row(16'hFFFF, 1'b1, 1'b0, 1'b0));
    plan.push_back(req_row(ebrs_pkg::CMD_START, 16'd0, 8'd0, 8'd0, 8'd0));
    plan.push_back(req_row(ebrs_pkg::CMD_POLL, 16'd0, 8'd7, 8'd204, 8'd170));
    plan.push_back(req_row(ebrs_pkg::CMD_POLL, 16'd1023, 8'd255, 8'd0, 8'd0));
    plan.push_back(req_row(ebrs_pkg::CMD_POLL, 16'd1024, 8'd200, 8'd0, 8'd0));
    plan.push_back(req_row(ebrs_pkg::CMD_POLL, 16'd5, 8'd1, 8'd0, 8'd171));
    plan.push_back(req_row(ebrs_pkg::CMD_PEAK, 16'd0, 8'd0, 8'd0, 8'd0));
    // spin in reverse near target: sensors and shortcut ignored, slow speed
    plan.push_back(set_row(16'd10, 1'b1, 1'b1, 1'b1));
    plan.push_back(req_row(ebrs_pkg::CMD_START, 16'd0, 8'd0, 8'd0, 8'd0));
    plan.push_back(req_row(ebrs_pkg::CMD_POLL, 16'd9, 8'd255, 8'd255, 8'd255));
    plan.push_back(req_row(ebrs_pkg::CMD_POLL, 16'd10, 8'd0, 8'd0, 8'd0));
    plan.push_back(req_row(ebrs_pkg::CMD_PEAK, 16'd0, 8'd0, 8'd0, 8'd0));
    plan.push_back(set_row(16'd3, 1'b0, 1'b1, 1'b0));
    plan.push_back(req_row(ebrs_pkg::CMD_START, 16'd0, 8'd0, 8'd0, 8'd0));
    plan.push_back(req_row(ebrs_pkg::CMD_POLL, 16'hFFFF, 8'd0, 8'd0, 8'd0));
    plan.push_back(req_row(ebrs_pkg::CMD_PEAK, 16'd0, 8'd0, 8'd0, 8'd0));
    plan.push_back(set_row(16'd0, 1'b0, 1'b0, 1'b0));
    plan.push_back(req_row(ebrs_pkg::CMD_START, 16'd0, 8'd0, 8'd0, 8'd0));
    plan.push_back(req_row(ebrs_pkg::CMD_POLL, 16'd3, 8'd0, 8'd205, 8'd0));
    plan.push_back(req_row(CMD_UNUSED, 16'hFFFF, 8'hFF, 8'hFF, 8'hFF));

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_SET)
        reconfigure(plan[i].target, plan[i].spin, plan[i].back, plan[i].early);
      else
        issue(plan[i].item, plan[i].golden, plan[i].want);
    end

    move = 0;
    while (sent < ITEM_GOAL) begin
      move++;
      calm  = (move >= 20 && move < 30);
      // one long move hammers two ticks of one bucket until it wraps
      heavy = (move == 12);
      case ($urandom_range(0, 4))
        0:       tgt = 16'd0;
        1:       tgt = 16'($urandom_range(1, 40));
        2:       tgt = 16'($urandom_range(41, 1100));
        3:       tgt = 16'hFFFF;
        default: tgt = 16'($urandom_range(0, 65535));
      endcase
      spin  = 1'($urandom_range(0, 1));
      back  = ($urandom_range(0, 9) < 3);
      early = 1'($urandom_range(0, 1));
      case ($urandom_range(0, 5))
        0:       base = 16'($urandom_range(0, 65535));
        1:       base = 16'($urandom_range(1000, 1030));
        default: base = 16'd0;
      endcase
      n_polls = $urandom_range(3, 30);
      dense   = ($urandom_range(0, 2) == 0);
      if (heavy) begin
        tgt     = 16'hFFFF;
        back    = 1'b0;
        early   = 1'b0;
        base    = 16'd2;
        n_polls = 280;
        dense   = 1'b1;
      end
      reconfigure(tgt, spin, back, early);
      if (heavy || $urandom_range(0, 9) != 0)
        issue(mk_req(ebrs_pkg::CMD_START, 16'($urandom_range(0, 65535)),
                     8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                     8'($urandom_range(0, 255))), 1'b0, '0);
      enc = base;
      for (int p = 0; p < n_polls; p++) begin
        if (!heavy && $urandom_range(0, 19) == 0) begin
          issue(mk_req(2'($urandom_range(0, 3)), 16'($urandom_range(0, 65535)),
                       8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                       8'($urandom_range(0, 255))), 1'b0, '0);
        end else begin
          if (heavy) enc = base + 16'(p % 2);
          else if (dense) enc = base + 16'($urandom_range(0, 3));
          else enc = enc + 16'($urandom_range(0, 3));
          if (heavy) rg = 8'd255;
          else if ($urandom_range(0, 1) != 0) rg = 8'($urandom_range(0, 255));
          else rg = 8'($urandom_range(0, 60));
          if (!heavy && $urandom_range(0, 9) == 0) begin
            rl = 8'($urandom_range(0, 255));
            ll = 8'($urandom_range(0, 255));
          end else begin
            rl = 8'($urandom_range(0, 204));
            ll = 8'($urandom_range(0, 170));
          end
          issue(mk_req(ebrs_pkg::CMD_POLL, enc, rg, rl, ll), 1'b0, '0);
        end
        if (!heavy && $urandom_range(0, 49) == 0) wait_drained();
      end
      issue(mk_req(ebrs_pkg::CMD_PEAK, 16'($urandom_range(0, 65535)),
                   8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                   8'($urandom_range(0, 255))), 1'b0, '0);
    end

    calm = 1'b0;
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("Drove %0d requests over %0d moves, %0d responses checked",
             sent, moves_seen, checked);
    $display("Stops: %0d at target, %0d on line, %0d by bucket shortcut; %0d peak reports",
             target_stops, line_stops, shortcut_stops, peaks_seen);
    if (errors == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule
